// ===== design/xpd_pkg.sv =====
package xpd_pkg;

    localparam int WINDOW_BYTES_DEF = 8;
    localparam int WINDOW_BYTES_MAX = 8;

    // Prefix and opcode bytes
    localparam logic [7:0] BYTE_OPSIZE  = 8'h66;
    localparam logic [7:0] BYTE_ADDRSZ  = 8'h67;
    localparam logic [7:0] BYTE_LOCK    = 8'hF0;
    localparam logic [7:0] BYTE_REPNE   = 8'hF2;
    localparam logic [7:0] BYTE_REP     = 8'hF3;
    localparam logic [7:0] BYTE_ESCAPE  = 8'h0F;
    localparam logic [7:0] BYTE_CMPSB   = 8'hA6;
    localparam logic [7:0] BYTE_CMPSW   = 8'hA7;
    localparam logic [7:0] BYTE_SCASB   = 8'hAE;
    localparam logic [7:0] BYTE_SCASW   = 8'hAF;
    localparam logic [7:0] BYTE_SEG_ES  = 8'h26;
    localparam logic [7:0] BYTE_SEG_CS  = 8'h2E;
    localparam logic [7:0] BYTE_SEG_SS  = 8'h36;
    localparam logic [7:0] BYTE_SEG_DS  = 8'h3E;
    localparam logic [7:0] BYTE_SEG_FS  = 8'h64;
    localparam logic [7:0] BYTE_SEG_GS  = 8'h65;

    // Segment override codes
    localparam logic [2:0] SEG_ES = 3'd0;
    localparam logic [2:0] SEG_CS = 3'd1;
    localparam logic [2:0] SEG_SS = 3'd2;
    localparam logic [2:0] SEG_DS = 3'd3;
    localparam logic [2:0] SEG_FS = 3'd4;
    localparam logic [2:0] SEG_GS = 3'd5;

    localparam logic [1:0] MATCH_WEAK = 2'd1;
    localparam logic [1:0] MATCH_FULL = 2'd2;

    typedef struct packed {
        logic [63:0] byte_window;
        logic [2:0]  operand_32_mask;
    } t_in;

    typedef struct packed {
        logic [3:0] prefix_count;
        logic       opsize_override;
        logic       addrsize_override;
        logic       lock_seen;
        logic       repne_seen;
        logic       rep_seen;
        logic       repe_seen;
        logic       segment_valid;
        logic [2:0] segment_code;
        logic       address_size_32;
        logic [1:0] match_quality;
        logic       window_exhausted;
    } t_out;

    // What one byte lane found
    typedef struct packed {
        logic       cont;    // byte is an accepted prefix, scan goes on
        logic       exh;     // rep prefix with its lookahead byte missing
        logic       opov;
        logic       adov;
        logic       lock;
        logic       repne;
        logic       rep;
        logic       repe;
        logic       segv;
        logic [2:0] segc;
    } t_lane;

endpackage

// ===== design/x86_prefix_decoder.sv =====
// x86 instruction prefix decoder.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transfer carries a
// window of instruction bytes, byte zero in bits 7:0, plus the 3-bit mask of
// candidate operands that are 32-bit. Output channel (o_out_valid /
// i_out_ready / o_out_data): one decoded prefix summary per input transfer,
// in order.
// Config: i_cfg_we writes i_cfg_wdata into the default-mode bit (1 = 32-bit
// code); write it only while no transfer is in flight.
//
// One byte lane per window position classifies its byte, using the next byte
// as lookahead; a merge stage walks the lanes in order, stops at the first
// non-prefix and folds the flags into the output register.
// Each result is registered (output or skid register). Throughput: 1 item
// per cycle while i_out_ready holds, set by the single output register stage.
// Stall: a two-entry output buffer (output register plus skid register)
// keeps taking one more item while the receiver stalls; o_in_ready drops
// only when both entries hold results.
// Reset (synchronous, active low): both buffers empty, default mode 32-bit.
module x86_prefix_decoder #(
    parameter int WINDOW_BYTES = xpd_pkg::WINDOW_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  xpd_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output xpd_pkg::t_out  o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata
);

    xpd_pkg::t_lane [WINDOW_BYTES-1:0] lanes;
    xpd_pkg::t_out                     result;

    logic          r_mode_32;
    logic          r_out_valid;
    xpd_pkg::t_out r_out;
    logic          r_skid_valid;
    xpd_pkg::t_out r_skid;
    logic          in_xfer;

    // Byte lanes: the last lane has no lookahead byte
    for (genvar k = 0; k < WINDOW_BYTES; k++) begin : g_lane
        logic [7:0] next_byte;
        if (k + 1 < WINDOW_BYTES) begin : g_next
            assign next_byte = i_in_data.byte_window[8*(k+1) +: 8];
        end else begin : g_edge
            assign next_byte = 8'h00;
        end
        xpd_lane u_lane (
            .i_byte       (i_in_data.byte_window[8*k +: 8]),
            .i_next       (next_byte),
            .i_next_valid ((k + 1) < WINDOW_BYTES),
            .o_lane       (lanes[k])
        );
    end

    xpd_merge #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_merge (
        .i_lanes   (lanes),
        .i_mode_32 (r_mode_32),
        .i_mask    (i_in_data.operand_32_mask),
        .o_res     (result)
    );

    // Default-mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_32 <= 1'b1;
        end else if (i_cfg_we) begin
            r_mode_32 <= i_cfg_wdata;
        end
    end

    assign o_in_ready = !r_skid_valid;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Output buffer control: park a new result in the skid entry while the
    // receiver stalls, refill the output register from skid first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_out_ready) begin
            if (in_xfer) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= in_xfer;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_out_ready) begin
            if (in_xfer) begin
                r_skid <= result;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (in_xfer) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/xpd_lane.sv =====
module xpd_lane (
    input  logic          [7:0] i_byte,
    input  logic          [7:0] i_next,
    input  logic                i_next_valid,
    output xpd_pkg::t_lane      o_lane
);

    logic str_cmp;

    assign str_cmp = (i_next == xpd_pkg::BYTE_CMPSB) || (i_next == xpd_pkg::BYTE_CMPSW) ||
                     (i_next == xpd_pkg::BYTE_SCASB) || (i_next == xpd_pkg::BYTE_SCASW);

    always_comb begin
        o_lane = '0;
        unique case (i_byte)
            xpd_pkg::BYTE_OPSIZE: begin
                o_lane.cont = 1'b1;
                o_lane.opov = 1'b1;
            end
            xpd_pkg::BYTE_ADDRSZ: begin
                o_lane.cont = 1'b1;
                o_lane.adov = 1'b1;
            end
            xpd_pkg::BYTE_LOCK: begin
                o_lane.cont = 1'b1;
                o_lane.lock = 1'b1;
            end
            xpd_pkg::BYTE_REPNE, xpd_pkg::BYTE_REP: begin
                // stop at the window edge; F2/F3 before 0F opens the opcode
                if (!i_next_valid) begin
                    o_lane.exh = 1'b1;
                end else if (i_next != xpd_pkg::BYTE_ESCAPE) begin
                    o_lane.cont  = 1'b1;
                    o_lane.repne = (i_byte == xpd_pkg::BYTE_REPNE);
                    o_lane.repe  = (i_byte == xpd_pkg::BYTE_REP) && str_cmp;
                    o_lane.rep   = (i_byte == xpd_pkg::BYTE_REP) && !str_cmp;
                end
            end
            xpd_pkg::BYTE_SEG_ES: begin
                o_lane.cont = 1'b1;
                o_lane.segv = 1'b1;
                o_lane.segc = xpd_pkg::SEG_ES;
            end
            xpd_pkg::BYTE_SEG_CS: begin
                o_lane.cont = 1'b1;
                o_lane.segv = 1'b1;
                o_lane.segc = xpd_pkg::SEG_CS;
            end
            xpd_pkg::BYTE_SEG_SS: begin
                o_lane.cont = 1'b1;
                o_lane.segv = 1'b1;
                o_lane.segc = xpd_pkg::SEG_SS;
            end
            xpd_pkg::BYTE_SEG_DS: begin
                o_lane.cont = 1'b1;
                o_lane.segv = 1'b1;
                o_lane.segc = xpd_pkg::SEG_DS;
            end
            xpd_pkg::BYTE_SEG_FS: begin
                o_lane.cont = 1'b1;
                o_lane.segv = 1'b1;
                o_lane.segc = xpd_pkg::SEG_FS;
            end
            xpd_pkg::BYTE_SEG_GS: begin
                o_lane.cont = 1'b1;
                o_lane.segv = 1'b1;
                o_lane.segc = xpd_pkg::SEG_GS;
            end
            default: begin
                o_lane.cont = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/xpd_merge.sv =====
module xpd_merge #(
    parameter int WINDOW_BYTES = xpd_pkg::WINDOW_BYTES_DEF
) (
    input  xpd_pkg::t_lane [WINDOW_BYTES-1:0] i_lanes,
    input  logic                              i_mode_32,
    input  logic           [2:0]              i_mask,
    output xpd_pkg::t_out                     o_res
);

    logic       alive;
    logic [3:0] count;
    logic       opov, adov, lock, repne, rep, repe, segv, exh;
    logic [2:0] segc;
    logic       eff32;
    logic       full;

    // Walk the lanes in byte order; everything after the first stop is dropped
    always_comb begin
        alive = 1'b1;
        count = '0;
        opov  = 1'b0;
        adov  = 1'b0;
        lock  = 1'b0;
        repne = 1'b0;
        rep   = 1'b0;
        repe  = 1'b0;
        segv  = 1'b0;
        segc  = xpd_pkg::SEG_ES;
        exh   = 1'b0;
        for (int k = 0; k < WINDOW_BYTES; k++) begin
            if (alive) begin
                if (i_lanes[k].cont) begin
                    count = count + 4'd1;
                    opov  = opov  | i_lanes[k].opov;
                    adov  = adov  | i_lanes[k].adov;
                    lock  = lock  | i_lanes[k].lock;
                    repne = repne | i_lanes[k].repne;
                    rep   = rep   | i_lanes[k].rep;
                    repe  = repe  | i_lanes[k].repe;
                    if (i_lanes[k].segv) begin
                        segv = 1'b1;
                        segc = i_lanes[k].segc;
                    end
                end else begin
                    alive = 1'b0;
                    exh   = i_lanes[k].exh;
                end
            end
        end
        // whole window was prefixes
        if (alive) begin
            exh = 1'b1;
        end
    end

    assign eff32 = i_mode_32 ^ opov;
    assign full  = eff32 ? (|i_mask) : ~(|i_mask);

    always_comb begin
        o_res                   = '0;
        o_res.prefix_count      = count;
        o_res.opsize_override   = opov;
        o_res.addrsize_override = adov;
        o_res.lock_seen         = lock;
        o_res.repne_seen        = repne;
        o_res.rep_seen          = rep;
        o_res.repe_seen         = repe;
        o_res.segment_valid     = segv;
        o_res.segment_code      = segc;
        o_res.address_size_32   = i_mode_32 ^ adov;
        o_res.match_quality     = full ? xpd_pkg::MATCH_FULL : xpd_pkg::MATCH_WEAK;
        o_res.window_exhausted  = exh;
    end

endmodule

// ===== design/xpd_checker.sv =====
module xpd_checker #(
    parameter int WINDOW_BYTES = xpd_pkg::WINDOW_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           o_in_ready,
    input  xpd_pkg::t_out  o_out_data,
    input  logic           o_out_valid,
    input  logic           i_out_ready
);

    // Held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    // After every input transfer, o_out_valid is high on the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("result missing after input transfer");

    a_quality: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.match_quality == xpd_pkg::MATCH_WEAK ||
                         o_out_data.match_quality == xpd_pkg::MATCH_FULL))
        else $error("match quality out of range");

    a_no_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.segment_valid |-> o_out_data.segment_code == xpd_pkg::SEG_ES)
        else $error("segment code set without override");

    a_full_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.prefix_count == 4'(WINDOW_BYTES))
        |-> o_out_data.window_exhausted)
        else $error("full prefix window not flagged exhausted");

endmodule

bind x86_prefix_decoder xpd_checker #(
    .WINDOW_BYTES (WINDOW_BYTES)
) u_xpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_data  (o_out_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);
